// ----- sv/ntcp_pkg.sv -----
// ----------------------------------------------------------------------------
// ntcp_pkg
// Shared types, codes and command tables for the NDEF text command parser.
// ----------------------------------------------------------------------------
package ntcp_pkg;

  localparam int BUFFER_BYTES_DEF = 256;
  localparam int CNT_W            = 9;
  localparam int CMD_COUNT        = 3;

  localparam logic [7:0] HDR_SHORT_TEXT = 8'hD1;
  localparam logic [7:0] TYPE_TEXT      = 8'h54;
  localparam logic [5:0] LANG_MASK      = 6'h3F;
  localparam logic [CNT_W-1:0] MIN_FILE = CNT_W'(8);

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_TOO_LARGE  = 4'd1,
    ST_TOO_SHORT  = 4'd2,
    ST_BAD_LENGTH = 4'd3,
    ST_BAD_HEADER = 4'd4,
    ST_NOT_TEXT   = 4'd5,
    ST_OVERFLOW   = 4'd6,
    ST_EMPTY      = 4'd7,
    ST_UTF16      = 4'd8,
    ST_BAD_LANG   = 4'd9,
    ST_UNKNOWN    = 4'd10
  } status_t;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_CONFIG = 2'd1,
    MODE_DIAG   = 2'd2
  } mode_t;

  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic [15:0]      msg_len;
    logic [7:0]       header;
    logic [7:0]       type_len;
    logic [7:0]       type_char;
    logic [7:0]       payload_len;
    logic [7:0]       text_status;
    logic [2:0]       match;
  } summary_t;

  function automatic logic [4:0] cmd_len(input logic [1:0] k);
    logic [4:0] r;
    case (k)
      2'd0:    r = 5'd11;
      2'd1:    r = 5'd11;
      2'd2:    r = 5'd15;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] cmd_char(input logic [1:0] k, input logic [3:0] idx);
    logic [7:0] r;
    r = 8'h00;
    case (idx)
      4'd0:  r = "M";
      4'd1:  r = "O";
      4'd2:  r = "D";
      4'd3:  r = "E";
      4'd4:  r = "=";
      default: begin
        case (k)
          2'd0: begin
            case (idx)
              4'd5:    r = "N";
              4'd6:    r = "O";
              4'd7:    r = "R";
              4'd8:    r = "M";
              4'd9:    r = "A";
              4'd10:   r = "L";
              default: r = 8'h00;
            endcase
          end
          2'd1: begin
            case (idx)
              4'd5:    r = "C";
              4'd6:    r = "O";
              4'd7:    r = "N";
              4'd8:    r = "F";
              4'd9:    r = "I";
              4'd10:   r = "G";
              default: r = 8'h00;
            endcase
          end
          2'd2: begin
            case (idx)
              4'd5:    r = "D";
              4'd6:    r = "I";
              4'd7:    r = "A";
              4'd8:    r = "G";
              4'd9:    r = "N";
              4'd10:   r = "O";
              4'd11:   r = "S";
              4'd12:   r = "T";
              4'd13:   r = "I";
              4'd14:   r = "C";
              default: r = 8'h00;
            endcase
          end
          default: r = 8'h00;
        endcase
      end
    endcase
    return r;
  endfunction

endpackage

// ----- sv/ntcp_front.sv -----
// ----------------------------------------------------------------------------
// ntcp_front
// Byte intake: counts bytes, captures header fields, matches command text.
// ----------------------------------------------------------------------------
module ntcp_front #(
  parameter int BUFFER_BYTES = ntcp_pkg::BUFFER_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  output logic              push,
  output ntcp_pkg::summary_t push_data,
  input  logic              q_full
);
  import ntcp_pkg::*;

  localparam logic [CNT_W-1:0] BUF_LIM = CNT_W'(BUFFER_BYTES);

  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [15:0]      message_length, message_length_next;
  logic [7:0]       record_header, record_header_next;
  logic [7:0]       type_len, type_len_next;
  logic [7:0]       type_char, type_char_next;
  logic [7:0]       payload_len, payload_len_next;
  logic [7:0]       text_status, text_status_next;
  logic [2:0]       match_flags, match_flags_next;

  logic             take;
  logic [CNT_W-1:0] txt_start;
  logic [9:0]       txt_end;
  logic [CNT_W-1:0] txt_idx;
  logic             in_text;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  assign txt_start = CNT_W'(7) + CNT_W'(text_status[5:0] & LANG_MASK);
  assign txt_end   = 10'd6 + {2'b00, payload_len};
  assign txt_idx   = byte_count - txt_start;
  assign in_text   = (byte_count >= CNT_W'(7)) && (byte_count <= BUF_LIM) &&
                     (byte_count >= txt_start) && ({1'b0, byte_count} < txt_end);

  always_comb begin
    message_length_next = message_length;
    record_header_next  = record_header;
    type_len_next       = type_len;
    type_char_next      = type_char;
    payload_len_next    = payload_len;
    text_status_next    = text_status;
    match_flags_next    = match_flags;
    unique case (byte_count)
      CNT_W'(0): message_length_next = {in_byte, 8'h00};
      CNT_W'(1): message_length_next = {message_length[15:8], in_byte};
      CNT_W'(2): record_header_next  = in_byte;
      CNT_W'(3): type_len_next       = in_byte;
      CNT_W'(4): payload_len_next    = in_byte;
      CNT_W'(5): type_char_next      = in_byte;
      CNT_W'(6): text_status_next    = in_byte;
      default: begin
        if (in_text) begin
          for (int k = 0; k < CMD_COUNT; k++) begin
            if ((txt_idx >= CNT_W'(cmd_len(2'(k)))) ||
                (cmd_char(2'(k), txt_idx[3:0]) != in_byte)) begin
              match_flags_next[k] = 1'b0;
            end
          end
        end
      end
    endcase
    byte_count_next = (byte_count <= BUF_LIM) ? byte_count + CNT_W'(1) : byte_count;
  end

  assign push = take && in_last;

  always_comb begin
    push_data.n           = byte_count_next;
    push_data.msg_len     = message_length_next;
    push_data.header      = record_header_next;
    push_data.type_len    = type_len_next;
    push_data.type_char   = type_char_next;
    push_data.payload_len = payload_len_next;
    push_data.text_status = text_status_next;
    push_data.match       = match_flags_next;
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      byte_count     <= '0;
      message_length <= '0;
      record_header  <= '0;
      type_len       <= '0;
      type_char      <= '0;
      payload_len    <= '0;
      text_status    <= '0;
      match_flags    <= '1;
    end else if (take) begin
      byte_count     <= byte_count_next;
      message_length <= message_length_next;
      record_header  <= record_header_next;
      type_len       <= type_len_next;
      type_char      <= type_char_next;
      payload_len    <= payload_len_next;
      text_status    <= text_status_next;
      match_flags    <= match_flags_next;
    end
  end

endmodule

// ----- sv/ntcp_queue.sv -----
// ----------------------------------------------------------------------------
// ntcp_queue
// Two-entry queue of finished file summaries between intake and judging.
// ----------------------------------------------------------------------------
module ntcp_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ntcp_pkg::summary_t push_data,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output ntcp_pkg::summary_t head_data
);
  import ntcp_pkg::*;

  summary_t   entry [2];
  logic       wptr, rptr;
  logic [1:0] count;
  logic       do_push, do_pop;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_data  = entry[rptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= !wptr;
      end
      if (do_pop) begin
        rptr <= !rptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ----- sv/ntcp_back.sv -----
// ----------------------------------------------------------------------------
// ntcp_back
// Judging stage: orders the file checks and holds the result for the receiver.
// ----------------------------------------------------------------------------
module ntcp_back #(
  parameter int BUFFER_BYTES = ntcp_pkg::BUFFER_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  ntcp_pkg::summary_t head_data,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_status,
  output logic [1:0]         out_mode
);
  import ntcp_pkg::*;

  localparam logic [CNT_W-1:0] BUF_LIM = CNT_W'(BUFFER_BYTES);

  status_t    status;
  mode_t      mode;
  logic [5:0] lang;
  logic [7:0] tlen;
  logic [9:0] rec_len;

  assign lang    = head_data.text_status[5:0] & LANG_MASK;
  assign tlen    = head_data.payload_len - 8'd1 - {2'b00, lang};
  assign rec_len = 10'd3 + {2'b00, head_data.type_len} + {2'b00, head_data.payload_len};

  always_comb begin
    status = ST_UNKNOWN;
    mode   = MODE_NORMAL;
    if (head_data.n > BUF_LIM) begin
      status = ST_TOO_LARGE;
    end else if (head_data.n < MIN_FILE) begin
      status = ST_TOO_SHORT;
    end else if ({1'b0, head_data.msg_len} + 17'd2 > {8'h00, head_data.n}) begin
      status = ST_BAD_LENGTH;
    end else if (head_data.header != HDR_SHORT_TEXT) begin
      status = ST_BAD_HEADER;
    end else if (head_data.type_len != 8'd1 || head_data.type_char != TYPE_TEXT) begin
      status = ST_NOT_TEXT;
    end else if ({6'h00, rec_len} > head_data.msg_len) begin
      status = ST_OVERFLOW;
    end else if (head_data.payload_len == 8'd0) begin
      status = ST_EMPTY;
    end else if (head_data.text_status[7]) begin
      status = ST_UTF16;
    end else if ({2'b00, lang} + 8'd1 > head_data.payload_len) begin
      status = ST_BAD_LANG;
    end else if (head_data.match[0] && tlen == {3'b000, cmd_len(2'd0)}) begin
      status = ST_OK;
      mode   = MODE_NORMAL;
    end else if (head_data.match[1] && tlen == {3'b000, cmd_len(2'd1)}) begin
      status = ST_OK;
      mode   = MODE_CONFIG;
    end else if (head_data.match[2] && tlen == {3'b000, cmd_len(2'd2)}) begin
      status = ST_OK;
      mode   = MODE_DIAG;
    end
  end

  assign pop = head_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_status <= status;
      out_mode   <= mode;
    end
  end

endmodule

// ----- sv/ndef_text_command_parser_unit.sv -----
// ----------------------------------------------------------------------------
// ndef_text_command_parser_unit
// Parses a written NFC Type 4 file into a status and a requested mode.
// ----------------------------------------------------------------------------
// Input stream s_axis: one file byte per request in tdata, tlast on the final
// byte. Output stream m_axis: one request per file, issued for the byte that
// carried tlast, with the parse status and the mode.
// Throughput: one input byte per cycle; s_axis_tready drops only when the
// two-entry summary queue is full.
// Result path: the queue is written at the edge that takes the last byte, and
// the judging register then takes the summary from the queue head onto m_axis.
// When the receiver stalls, the result holds in the output register, further
// files collect in the queue, and intake halts once a third file ends.
// Reset clears the byte count, the captured fields, the queue and the output
// valid; the next byte taken is byte 0 of a new file.
// ----------------------------------------------------------------------------
module ndef_text_command_parser_unit #(
  parameter int BUFFER_BYTES = ntcp_pkg::BUFFER_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [3:0] parse_status, [5:4] command_mode, [7:6] zero
);
  import ntcp_pkg::*;

  logic       push, q_full, pop, head_valid;
  summary_t   push_data, head_data;
  logic [3:0] status;
  logic [1:0] mode;

  ntcp_front #(.BUFFER_BYTES(BUFFER_BYTES)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_byte   (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  ntcp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  ntcp_back #(.BUFFER_BYTES(BUFFER_BYTES)) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_status (status),
    .out_mode   (mode)
  );

  assign m_axis_tdata = {2'b00, mode, status};

endmodule

// ----- sv/ntcp_checker.sv -----
// ----------------------------------------------------------------------------
// ntcp_checker
// Port-level checks on the parser result stream and on intake ready after reset.
// ----------------------------------------------------------------------------
module ntcp_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);
  import ntcp_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  a_ready_reset: assert property (@(posedge clk) rst |=> s_axis_tready)
    else $error("intake not ready after reset");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[3:0] <= ST_UNKNOWN && m_axis_tdata[7:6] == 2'b00)
    else $error("status code out of range");

  a_mode: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[3:0] == ST_OK && m_axis_tdata[5:4] != 2'd3) ||
                      m_axis_tdata[5:4] == MODE_NORMAL)
    else $error("mode given with failing status");

endmodule

bind ndef_text_command_parser_unit ntcp_checker u_ntcp_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
